### rtl/hgbr_pkg.sv
package hgbr_pkg;

    // Default sizes of the source store and of the resampled grid
    localparam int GRID_MAX_DEF = 256;
    localparam int RES_MAX_DEF  = 256;

    // Register reset values
    localparam logic [8:0]         GRID_SIDE_RST     = 9'd256;
    localparam logic [31:0]        SPACING_RST       = 32'd65536;
    localparam logic signed [31:0] CENTER_HEIGHT_RST = 32'sd0;

    typedef enum logic [1:0] {
        REG_GRID_SIDE     = 2'd0,
        REG_SPACING_X     = 2'd1,
        REG_SPACING_Y     = 2'd2,
        REG_CENTER_HEIGHT = 2'd3
    } cfg_reg_t;

endpackage

### rtl/hgbr_div.sv
// Pipelined restoring divider: one quotient bit per stage.
// ovf flags a numerator at or above den << QW.
module hgbr_div #(
    parameter int NUMW = 48,
    parameter int DENW = 33,
    parameter int QW   = 16
) (
    input  logic            clk,
    input  logic            en,
    input  logic [NUMW-1:0] num,
    input  logic [DENW-1:0] den,
    output logic [QW-1:0]   quo,
    output logic            ovf
);

    localparam int XW = (NUMW > DENW + QW) ? NUMW : DENW + QW;

    logic [XW-1:0]   rem_reg [QW+1];
    logic [DENW-1:0] den_reg [QW+1];
    logic [QW-1:0]   q_reg   [QW+1];
    logic            ovf_reg [QW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= XW'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= 1'b0;
        end
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_step
        localparam int K = QW - 1 - i;
        logic [XW-1:0] shifted;
        logic          ge;
        logic          ovf_next;

        assign shifted  = XW'(den_reg[i]) << K;
        assign ge       = rem_reg[i] >= shifted;
        assign ovf_next = (i == 0) ? (rem_reg[i] >= (XW'(den_reg[i]) << QW)) : ovf_reg[i];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? rem_reg[i] - shifted : rem_reg[i];
                den_reg[i+1] <= den_reg[i];
                q_reg[i+1]   <= q_reg[i] | (ge ? (QW'(1) << K) : '0);
                ovf_reg[i+1] <= ovf_next;
            end
        end
    end

    assign quo = q_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

### rtl/height_grid_bilinear_resampler_core.sv
// Height grid bilinear resampler.
// Item channel (item_valid/item_ready): action 0 loads sample_height into the
// source cell at (col,row); action 1 queries resampled cell (col,row). Loads
// give no result; each query gives one transfer on the result channel carrying
// the interpolated height minus centre height, in_range and the output sizes.
// Configuration is written through cfg_write_en/cfg_index/cfg_data; the user
// must write it only while idle, the block does not enforce this. Throughput:
// one item per cycle while item_ready is high. The size and position dividers
// run in series, pipelined restoring, one quotient bit per stage.
// Loads are written into the store at the read stage, so item order is kept.
// The store is four banks split by row and column parity, so the four
// neighbours are read in the same cycle.
// Reset clears the pipeline and result valids and restores the registers; the
// height store is not cleared and a cell must be loaded before it is read.
// When the receiver stalls, one result is held in the output register and a
// second in a skid register; only then does item_ready fall.
module height_grid_bilinear_resampler_core #(
    parameter int GRID_MAX = hgbr_pkg::GRID_MAX_DEF,
    parameter int RES_MAX  = hgbr_pkg::RES_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic               action,
    input  logic [7:0]         col,
    input  logic [7:0]         row,
    input  logic signed [31:0] sample_height,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [31:0] value,
    output logic               in_range,
    output logic [8:0]         out_cols,
    output logic [8:0]         out_rows,
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    import hgbr_pkg::*;

    localparam int IW   = $clog2(GRID_MAX);
    localparam int NW   = $clog2(GRID_MAX + 1);
    localparam int RW   = $clog2(RES_MAX + 1);
    localparam int TW   = ((RW + 1 > 9) ? RW + 1 : 9) + 1;
    localparam int PMW  = 33 + TW;
    localparam int NAW  = NW + 34;
    localparam int QIW  = $clog2(2 * RES_MAX + GRID_MAX / 2 + 1);
    localparam int QB   = QIW + 16;
    localparam int NBW  = 33 + QB;
    localparam int SUMW = 36 + TW + NW + RW;
    localparam int IXW  = QIW + 2;
    localparam int LA   = RW + 1;
    localparam int LB   = QB + 1;
    localparam int KA   = 1 + LA;
    localparam int KB   = KA + 2 + LB;
    localparam int KF   = KB + 7;
    localparam int NS   = KF + 1;
    localparam int HC   = (GRID_MAX + 1) / 2;
    localparam int BD   = HC * HC;
    localparam int BAW  = (BD > 1) ? $clog2(BD) : 1;

    typedef struct packed {
        logic               query;
        logic [7:0]         col;
        logic [7:0]         row;
        logic signed [31:0] height;
        logic               hit;
        logic [RW-1:0]      rx;
        logic [RW-1:0]      ry;
    } item_t;

    // ---------------------------------------------------------------- config
    logic [8:0]         grid_side_reg;
    logic [31:0]        spacing_x_reg;
    logic [31:0]        spacing_y_reg;
    logic signed [31:0] center_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg     <= GRID_SIDE_RST;
            spacing_x_reg     <= SPACING_RST;
            spacing_y_reg     <= SPACING_RST;
            center_height_reg <= CENTER_HEIGHT_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GRID_SIDE:     grid_side_reg     <= cfg_data[8:0];
                REG_SPACING_X:     spacing_x_reg     <= cfg_data;
                REG_SPACING_Y:     spacing_y_reg     <= cfg_data;
                REG_CENTER_HEIGHT: center_height_reg <= $signed(cfg_data);
                default:           grid_side_reg     <= grid_side_reg;
            endcase
        end
    end

    // Effective settings; the user must keep them static while items are in flight, the block does not enforce this
    logic [NW-1:0] side_n;
    logic [IW-1:0] side_max;
    logic [31:0]   dx;
    logic [31:0]   dy;
    logic [31:0]   dmin;

    always_comb
    begin
        if (grid_side_reg == 9'd0)
            side_n = NW'(1);
        else if (32'(grid_side_reg) > GRID_MAX)
            side_n = NW'(GRID_MAX);
        else
            side_n = NW'(grid_side_reg);
        side_max = IW'(side_n - NW'(1));
        dx       = (spacing_x_reg == 32'd0) ? 32'd1 : spacing_x_reg;
        dy       = (spacing_y_reg == 32'd0) ? 32'd1 : spacing_y_reg;
        dmin     = (dx < dy) ? dx : dy;
    end

    // ------------------------------------------------------- pipeline control
    logic          adv;
    logic [NS-1:0] valid_reg;
    item_t         pay_reg [NS];
    item_t         in_item;
    item_t         sized_item;

    logic skid_valid_reg;
    logic skid_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    assign adv        = ~skid_valid_reg;
    assign item_ready = adv;

    always_comb
    begin
        in_item        = '0;
        in_item.query  = action;
        in_item.col    = col;
        in_item.row    = row;
        in_item.height = sample_height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[NS-2:0], item_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay_reg[0] <= in_item;
            for (int k = 1; k < NS; k++)
                pay_reg[k] <= (k == KA + 1) ? sized_item : pay_reg[k-1];
        end
    end

    // ------------------------------------------------ output size (ceil div)
    logic [NW+31:0] nsx_reg;
    logic [NW+31:0] nsy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nsx_reg <= (NW+32)'(side_n) * (NW+32)'(dx);
            nsy_reg <= (NW+32)'(side_n) * (NW+32)'(dy);
        end
    end

    logic [32:0]    den_m;
    logic [NAW-1:0] sz_num_x;
    logic [NAW-1:0] sz_num_y;
    logic [RW-1:0]  sz_q_x;
    logic [RW-1:0]  sz_q_y;
    logic           sz_ovf_x;
    logic           sz_ovf_y;

    assign den_m    = {dmin, 1'b0};
    assign sz_num_x = NAW'(nsx_reg) + NAW'(den_m) - NAW'(1);
    assign sz_num_y = NAW'(nsy_reg) + NAW'(den_m) - NAW'(1);

    hgbr_div #(.NUMW(NAW), .DENW(33), .QW(RW)) u_size_x (
        .clk (clk),
        .en  (adv),
        .num (sz_num_x),
        .den (den_m),
        .quo (sz_q_x),
        .ovf (sz_ovf_x)
    );

    hgbr_div #(.NUMW(NAW), .DENW(33), .QW(RW)) u_size_y (
        .clk (clk),
        .en  (adv),
        .num (sz_num_y),
        .den (den_m),
        .quo (sz_q_y),
        .ovf (sz_ovf_y)
    );

    always_comb
    begin
        sized_item    = pay_reg[KA];
        sized_item.rx = (sz_ovf_x || 32'(sz_q_x) > RES_MAX) ? RW'(RES_MAX) : sz_q_x;
        sized_item.ry = (sz_ovf_y || 32'(sz_q_y) > RES_MAX) ? RW'(RES_MAX) : sz_q_y;
        sized_item.hit = (32'(pay_reg[KA].col) < 32'(sized_item.rx))
                      && (32'(pay_reg[KA].row) < 32'(sized_item.ry));
    end

    // ------------------------------------------------- source position terms
    logic signed [TW-1:0]  tx_next;
    logic signed [TW-1:0]  ty_next;
    logic signed [PMW-1:0] pmx_reg;
    logic signed [PMW-1:0] pmy_reg;
    logic [NW+31:0]        nsx2_reg;
    logic [NW+31:0]        nsy2_reg;
    logic [RW+31:0]        rsx_reg;
    logic [RW+31:0]        rsy_reg;

    assign tx_next = $signed(TW'({pay_reg[KA+1].col, 1'b0})) - $signed(TW'(pay_reg[KA+1].rx));
    assign ty_next = $signed(TW'({pay_reg[KA+1].row, 1'b0})) - $signed(TW'(pay_reg[KA+1].ry));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pmx_reg  <= $signed({1'b0, dmin}) * tx_next;
            pmy_reg  <= $signed({1'b0, dmin}) * ty_next;
            nsx2_reg <= (NW+32)'(side_n) * (NW+32)'(dx);
            nsy2_reg <= (NW+32)'(side_n) * (NW+32)'(dy);
            rsx_reg  <= (RW+32)'(RES_MAX) * (RW+32)'(dx);
            rsy_reg  <= (RW+32)'(RES_MAX) * (RW+32)'(dy);
        end
    end

    // Biased by RES_MAX cells so the dividend is never negative
    logic signed [SUMW-1:0] sumx;
    logic signed [SUMW-1:0] sumy;
    logic [NBW-1:0]         pos_num_x;
    logic [NBW-1:0]         pos_num_y;
    logic [QB-1:0]          pos_q_x;
    logic [QB-1:0]          pos_q_y;
    logic                   pos_ovf_x;
    logic                   pos_ovf_y;

    assign sumx = (SUMW'(pmx_reg) <<< 1) + $signed(SUMW'(nsx2_reg))
                + $signed(SUMW'({rsx_reg, 1'b0}));
    assign sumy = (SUMW'(pmy_reg) <<< 1) + $signed(SUMW'(nsy2_reg))
                + $signed(SUMW'({rsy_reg, 1'b0}));
    assign pos_num_x = {sumx[33+QIW-1:0], 16'b0};
    assign pos_num_y = {sumy[33+QIW-1:0], 16'b0};

    hgbr_div #(.NUMW(NBW), .DENW(33), .QW(QB)) u_pos_x (
        .clk (clk),
        .en  (adv),
        .num (pos_num_x),
        .den ({dx, 1'b0}),
        .quo (pos_q_x),
        .ovf (pos_ovf_x)
    );

    hgbr_div #(.NUMW(NBW), .DENW(33), .QW(QB)) u_pos_y (
        .clk (clk),
        .en  (adv),
        .num (pos_num_y),
        .den ({dy, 1'b0}),
        .quo (pos_q_y),
        .ovf (pos_ovf_y)
    );

    // ------------------------------------------------------ clamp to edge
    function automatic logic [IW-1:0] clamp_idx(input logic signed [IXW-1:0] i,
                                                input logic [IW-1:0] hi);
        logic [IW-1:0] r;
        if (i < 0)
            r = '0;
        else if (i > $signed({1'b0, hi}))
            r = hi;
        else
            r = i[IW-1:0];
        return r;
    endfunction

    logic signed [IXW-1:0] ix_next;
    logic signed [IXW-1:0] iy_next;
    logic [IW-1:0]         x0_reg;
    logic [IW-1:0]         x1_reg;
    logic [IW-1:0]         y0_reg;
    logic [IW-1:0]         y1_reg;
    logic [15:0]           fx6_reg;
    logic [15:0]           fy6_reg;

    assign ix_next = $signed(IXW'(pos_q_x[QB-1:16])) - IXW'(RES_MAX);
    assign iy_next = $signed(IXW'(pos_q_y[QB-1:16])) - IXW'(RES_MAX);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg  <= clamp_idx(ix_next, side_max);
            x1_reg  <= clamp_idx(ix_next + IXW'(1), side_max);
            y0_reg  <= clamp_idx(iy_next, side_max);
            y1_reg  <= clamp_idx(iy_next + IXW'(1), side_max);
            fx6_reg <= pos_q_x[15:0] | {15'd0, pos_ovf_x & 1'b0};
            fy6_reg <= pos_q_y[15:0] | {15'd0, pos_ovf_y & 1'b0};
        end
    end

    // ---------------------------------------------------- banked source store
    logic signed [31:0] rd_reg [4];
    logic               load_ok;
    logic               load_we;
    logic [BAW-1:0]     load_addr;
    item_t              ld;

    assign ld        = pay_reg[KB+1];
    assign load_ok   = (32'(ld.col) < GRID_MAX) && (32'(ld.row) < GRID_MAX);
    assign load_we   = adv && valid_reg[KB+1] && !ld.query && load_ok;
    assign load_addr = BAW'(32'(ld.row >> 1) * HC + 32'(ld.col >> 1));

    for (genvar py = 0; py < 2; py++)
    begin : g_brow
        for (genvar px = 0; px < 2; px++)
        begin : g_bcol
            logic signed [31:0] mem [BD];
            logic [IW-1:0]      rsel;
            logic [IW-1:0]      csel;
            logic [BAW-1:0]     raddr;
            logic               we;

            assign rsel  = (y0_reg[0] == 1'(py)) ? y0_reg : y1_reg;
            assign csel  = (x0_reg[0] == 1'(px)) ? x0_reg : x1_reg;
            assign raddr = BAW'(32'(rsel >> 1) * HC + 32'(csel >> 1));
            assign we    = load_we && (ld.row[0] == 1'(py)) && (ld.col[0] == 1'(px));

            always_ff @(posedge clk)
            begin
                if (we)
                    mem[load_addr] <= ld.height;
                if (adv)
                    rd_reg[py*2+px] <= mem[raddr];
            end
        end
    end

    logic       px0_reg;
    logic       px1_reg;
    logic       py0_reg;
    logic       py1_reg;
    logic [15:0] fx7_reg;
    logic [15:0] fy7_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px0_reg <= x0_reg[0];
            px1_reg <= x1_reg[0];
            py0_reg <= y0_reg[0];
            py1_reg <= y1_reg[0];
            fx7_reg <= fx6_reg;
            fy7_reg <= fy6_reg;
        end
    end

    // --------------------------------------------- route and remove centre
    logic signed [32:0] v00_reg;
    logic signed [32:0] v01_reg;
    logic signed [32:0] v10_reg;
    logic signed [32:0] v11_reg;
    logic [15:0]        fx8_reg;
    logic [15:0]        fy8_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v00_reg <= 33'(rd_reg[{py0_reg, px0_reg}]) - 33'(center_height_reg);
            v01_reg <= 33'(rd_reg[{py1_reg, px0_reg}]) - 33'(center_height_reg);
            v10_reg <= 33'(rd_reg[{py0_reg, px1_reg}]) - 33'(center_height_reg);
            v11_reg <= 33'(rd_reg[{py1_reg, px1_reg}]) - 33'(center_height_reg);
            fx8_reg <= fx7_reg;
            fy8_reg <= fy7_reg;
        end
    end

    // ------------------------------------------------------- lerp along y
    logic signed [33:0] dl_next;
    logic signed [33:0] dr_next;
    logic signed [16:0] fys;
    logic signed [50:0] pl_reg;
    logic signed [50:0] pr_reg;
    logic signed [32:0] a0_reg;
    logic signed [32:0] a1_reg;
    logic [15:0]        fx9_reg;

    assign dl_next = 34'(v01_reg) - 34'(v00_reg);
    assign dr_next = 34'(v11_reg) - 34'(v10_reg);
    assign fys     = $signed({1'b0, fy8_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pl_reg  <= dl_next * fys;
            pr_reg  <= dr_next * fys;
            a0_reg  <= v00_reg;
            a1_reg  <= v10_reg;
            fx9_reg <= fx8_reg;
        end
    end

    logic signed [32:0] left_reg;
    logic signed [32:0] right_reg;
    logic [15:0]        fx10_reg;

    // Sum fits 33 bits, so the truncated floor term wraps correctly
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            left_reg  <= a0_reg + $signed(pl_reg[48:16]);
            right_reg <= a1_reg + $signed(pr_reg[48:16]);
            fx10_reg  <= fx9_reg;
        end
    end

    // ------------------------------------------------------- lerp along x
    logic signed [33:0] dh_next;
    logic signed [50:0] ph_reg;
    logic signed [32:0] left11_reg;

    assign dh_next = 34'(right_reg) - 34'(left_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ph_reg     <= dh_next * $signed({1'b0, fx10_reg});
            left11_reg <= left_reg;
        end
    end

    logic signed [32:0] raw_next;
    logic signed [31:0] fin_next;
    logic signed [31:0] fin_reg;

    always_comb
    begin
        raw_next = left11_reg + $signed(ph_reg[48:16]);
        if (!pay_reg[KF-1].hit)
            fin_next = '0;
        else if (raw_next[32] != raw_next[31])
            fin_next = raw_next[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            fin_next = raw_next[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            fin_reg <= fin_next;
    end

    // --------------------------------------------------- output and skid
    logic               push;
    logic signed [31:0] out_value_reg;
    logic               out_inside_reg;
    logic [RW-1:0]      out_rx_reg;
    logic [RW-1:0]      out_ry_reg;
    logic signed [31:0] skid_value_reg;
    logic               skid_inside_reg;
    logic [RW-1:0]      skid_rx_reg;
    logic [RW-1:0]      skid_ry_reg;

    assign push = adv && valid_reg[KF] && pay_reg[KF].query;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (result_ready)
                skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !result_ready)
                skid_valid_next = 1'b1;
            else
                out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (result_ready)
            begin
                out_value_reg  <= skid_value_reg;
                out_inside_reg <= skid_inside_reg;
                out_rx_reg     <= skid_rx_reg;
                out_ry_reg     <= skid_ry_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !result_ready)
            begin
                skid_value_reg  <= fin_reg;
                skid_inside_reg <= pay_reg[KF].hit;
                skid_rx_reg     <= pay_reg[KF].rx;
                skid_ry_reg     <= pay_reg[KF].ry;
            end
            else
            begin
                out_value_reg  <= fin_reg;
                out_inside_reg <= pay_reg[KF].hit;
                out_rx_reg     <= pay_reg[KF].rx;
                out_ry_reg     <= pay_reg[KF].ry;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign value        = out_value_reg;
    assign in_range     = out_inside_reg;
    assign out_cols     = 9'(out_rx_reg);
    assign out_rows     = 9'(out_ry_reg);

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import hgbr_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 80;

    typedef struct {
        logic signed [31:0] value;
        logic               in_range;
        logic [8:0]         out_cols;
        logic [8:0]         out_rows;
    } cell_result_t;

    class resample_scoreboard;
        int           heights [65536];
        bit           written [65536];
        logic [8:0]   side;
        logic [31:0]  sx;
        logic [31:0]  sy;
        longint       centre;
        cell_result_t awaiting [$];
        int           mismatches;
        int           results;
        int           loads;
        int           queries;

        function new();
            side = GRID_SIDE_RST;
            sx = SPACING_RST;
            sy = SPACING_RST;
            centre = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [31:0] data);
            case (idx)
                REG_GRID_SIDE:     side = data[8:0];
                REG_SPACING_X:     sx = data;
                REG_SPACING_Y:     sy = data;
                REG_CENTER_HEIGHT: centre = longint'(signed'(data));
                default: ;
            endcase
        endfunction

        function longint floor16(longint p);
            if (p >= 0)
                return p >>> 16;
            return -(((-p) + 65535) >>> 16);
        endfunction

        function longint lerp(longint a, longint b, longint f);
            return a + floor16((b - a) * f);
        endfunction

        function void dims(output longint n, output longint dx, output longint dy,
                           output longint m, output longint rx, output longint ry);
            longint den;
            n = longint'(side);
            if (n < 1)
                n = 1;
            if (n > 256)
                n = 256;
            dx = (sx == 0) ? 1 : longint'(sx);
            dy = (sy == 0) ? 1 : longint'(sy);
            m = (dx < dy) ? dx : dy;
            den = 2 * m;
            rx = (n * dx + den - 1) / den;
            ry = (n * dy + den - 1) / den;
            if (rx > 256) rx = 256;
            if (ry > 256) ry = 256;
            if (rx < 1) rx = 1;
            if (ry < 1) ry = 1;
        endfunction

        function void locate(longint c, longint r, longint s, longint m, longint n,
                             output longint idx, output longint frac);
            longint num;
            longint den;
            longint q;
            longint rem;
            num = 2 * m * (2 * c - r) + n * s;
            den = 2 * s;
            q = num / den;
            rem = num - q * den;
            if (rem < 0)
            begin
                q -= 1;
                rem += den;
            end
            idx = q;
            frac = (rem <<< 16) / den;
        endfunction

        function longint height_at(longint x, longint y, longint n);
            if (x < 0) x = 0;
            if (x > n - 1) x = n - 1;
            if (y < 0) y = 0;
            if (y > n - 1) y = n - 1;
            return longint'(heights[y * 256 + x]) - centre;
        endfunction

        function void note_item(logic act, logic [7:0] c, logic [7:0] r,
                                logic signed [31:0] h);
            longint n, dx, dy, m, rx, ry, xi, fx, yi, fy, lft, rgt, v;
            cell_result_t e;
            if (act == 1'b0)
            begin
                heights[int'(r) * 256 + int'(c)] = h;
                written[int'(r) * 256 + int'(c)] = 1'b1;
                loads++;
                return;
            end
            queries++;
            dims(n, dx, dy, m, rx, ry);
            v = 0;
            e.in_range = (c < rx) && (r < ry);
            if (e.in_range)
            begin
                locate(c, rx, dx, m, n, xi, fx);
                locate(r, ry, dy, m, n, yi, fy);
                lft = lerp(height_at(xi, yi, n), height_at(xi, yi + 1, n), fy);
                rgt = lerp(height_at(xi + 1, yi, n), height_at(xi + 1, yi + 1, n), fy);
                v = lerp(lft, rgt, fx);
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
            end
            e.value = v[31:0];
            e.out_cols = rx[8:0];
            e.out_rows = ry[8:0];
            awaiting = {awaiting, e};
        endfunction

        function void check_result(cell_result_t got);
            cell_result_t e;
            results++;
            if (awaiting.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0d in_range %0b", got.value,
                             got.in_range);
                return;
            end
            e = awaiting.pop_front();
            if (got.value !== e.value || got.in_range !== e.in_range
                || got.out_cols !== e.out_cols || got.out_rows !== e.out_rows)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp v=%0d r=%0b %0dx%0d got v=%0d r=%0b %0dx%0d",
                             e.value, e.in_range, e.out_cols, e.out_rows, got.value,
                             got.in_range, got.out_cols, got.out_rows);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    logic               action;
    logic [7:0]         col;
    logic [7:0]         row;
    logic signed [31:0] sample_height;
    logic               result_valid;
    logic               result_ready;
    logic signed [31:0] value;
    logic               in_range;
    logic [8:0]         out_cols;
    logic [8:0]         out_rows;
    logic               cfg_write_en;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    resample_scoreboard sb;
    int                 gap_style;
    bit                 stalled_once;

    height_grid_bilinear_resampler_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end

    // 0: no idling, 1: mostly short gaps with a few long ones
    function automatic int pick_gap();
        int r;
        if (gap_style == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    always @(posedge clk)
    begin
        cell_result_t got;
        if (rst_n && result_valid && result_ready)
        begin
            got.value = value;
            got.in_range = in_range;
            got.out_cols = out_cols;
            got.out_rows = out_rows;
            sb.check_result(got);
        end
    end

    // receiver: random ready pattern, one long hold-off while the sender keeps going
    initial
    begin
        int n;
        result_ready = 1'b0;
        stalled_once = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!stalled_once && sb.queries >= 200)
            begin
                stalled_once = 1'b1;
                result_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            result_ready <= 1'b1;
            n = $urandom_range(1, 24);
            repeat (n) @(posedge clk);
            n = pick_gap();
            if (n > 0)
            begin
                result_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic send(logic act, logic [7:0] c, logic [7:0] r, logic [31:0] h);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            item_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        item_valid <= 1'b1;
        action <= act;
        col <= c;
        row <= r;
        sample_height <= h;
        do @(posedge clk); while (!item_ready);
        sb.note_item(act, c, r, h);
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (sb.awaiting.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_regs(logic [8:0] side, logic [31:0] dx, logic [31:0] dy,
                              logic [31:0] ch);
        cfg_reg_t idx;
        logic [31:0] d;
        for (int i = 0; i < 4; i++)
        begin
            idx = cfg_reg_t'(i);
            case (idx)
                REG_GRID_SIDE: d = {23'd0, side};
                REG_SPACING_X: d = dx;
                REG_SPACING_Y: d = dy;
                default:       d = ch;
            endcase
            cfg_write_en <= 1'b1;
            cfg_index <= idx;
            cfg_data <= d;
            @(posedge clk);
            sb.set_reg(idx, d);
        end
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // every cell a query can reach must be loaded first
    task automatic fill_grid(int n, int kind);
        logic [31:0] h;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
            begin
                case (kind)
                    0: h = $urandom;
                    1: h = ((r + c) % 2) ? 32'h7fffffff : 32'h80000000;
                    default: h = $urandom_range(0, 65535) - 32768;
                endcase
                send(1'b0, c[7:0], r[7:0], h);
            end
    endtask

    task automatic random_query(int bias);
        longint n, dx, dy, m, rx, ry;
        logic [7:0] c, r;
        sb.dims(n, dx, dy, m, rx, ry);
        if ($urandom_range(0, 99) < bias)
        begin
            c = 8'($urandom_range(0, rx - 1));
            r = 8'($urandom_range(0, ry - 1));
        end
        else
        begin
            c = 8'($urandom);
            r = 8'($urandom);
        end
        send(1'b1, c, r, $urandom);
    endtask

    // load one clamped cell unless it already holds data
    task automatic load_once(longint x, longint y, longint n);
        longint cx, cy;
        cx = (x < 0) ? 0 : ((x > n - 1) ? n - 1 : x);
        cy = (y < 0) ? 0 : ((y > n - 1) ? n - 1 : y);
        if (!sb.written[cy * 256 + cx])
            send(1'b0, cx[7:0], cy[7:0], $urandom);
    endtask

    // query on a large grid, loading only the neighbours it reaches
    task automatic reach_query(int bias);
        longint n, dx, dy, m, rx, ry, xi, fx, yi, fy;
        logic [7:0] c, r;
        sb.dims(n, dx, dy, m, rx, ry);
        if ($urandom_range(0, 99) < bias)
        begin
            c = 8'($urandom_range(0, rx - 1));
            r = 8'($urandom_range(0, ry - 1));
        end
        else
        begin
            c = 8'($urandom);
            r = 8'($urandom);
        end
        if (c < rx && r < ry)
        begin
            sb.locate(c, rx, dx, m, n, xi, fx);
            sb.locate(r, ry, dy, m, n, yi, fy);
            load_once(xi, yi, n);
            load_once(xi + 1, yi, n);
            load_once(xi, yi + 1, n);
            load_once(xi + 1, yi + 1, n);
        end
        send(1'b1, c, r, $urandom);
    endtask

    function automatic logic [31:0] rand_spacing();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(1 << 12, 1 << 18);
            2: return 32'h10000 * $urandom_range(1, 4);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    initial
    begin
        int n;
        sb = new();
        gap_style = 1;
        rst_n = 1'b0;
        item_valid = 1'b0;
        action = 1'b0;
        col = '0;
        row = '0;
        sample_height = '0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small grid, corners and cells outside the output
        write_regs(9'd2, 32'h10000, 32'h10000, 32'h0);
        send(1'b0, 8'd0, 8'd0, 32'h7fffffff);
        send(1'b0, 8'd1, 8'd0, 32'h80000000);
        send(1'b0, 8'd0, 8'd1, 32'h0);
        send(1'b0, 8'd1, 8'd1, 32'hffffffff);
        send(1'b0, 8'd255, 8'd255, 32'h12345678);
        send(1'b1, 8'd0, 8'd0, 32'h0);
        send(1'b1, 8'd0, 8'd1, 32'hffffffff);
        send(1'b1, 8'd1, 8'd0, 32'h0);
        send(1'b1, 8'd255, 8'd0, 32'h0);
        send(1'b1, 8'd0, 8'd255, 32'h0);
        settle();

        // one-cell grid, extreme spacings and centre: saturates low
        write_regs(9'd1, 32'h1, 32'hffffffff, 32'h7fffffff);
        send(1'b0, 8'd0, 8'd0, 32'h80000000);
        send(1'b1, 8'd0, 8'd0, 32'h0);
        send(1'b1, 8'd0, 8'd255, 32'h0);
        send(1'b1, 8'd1, 8'd0, 32'h0);
        settle();

        // side of zero, zero spacing, lowest centre: saturates high
        write_regs(9'd0, 32'h0, 32'h20000, 32'h80000000);
        send(1'b0, 8'd0, 8'd0, 32'h7fffffff);
        send(1'b1, 8'd0, 8'd0, 32'h0);
        send(1'b1, 8'd3, 8'd0, 32'h0);
        settle();

        write_regs(9'd7, 32'hffffffff, 32'h1, 32'h100);
        fill_grid(7, 1);
        for (int i = 0; i < 6; i++)
            random_query(90);
        settle();

        // random phases with small grids
        for (int p = 0; p < 6; p++)
        begin
            gap_style = (p % 3 == 2) ? 0 : 1;
            n = $urandom_range(1, 8);
            write_regs(n[8:0], rand_spacing(), rand_spacing(), $urandom);
            fill_grid(n, $urandom_range(0, 2));
            for (int i = 0; i < 45; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send(1'b0, 8'($urandom), 8'($urandom), $urandom);
                else
                    random_query(85);
            end
            settle();
        end

        // full-size store, side above the maximum acts as the maximum
        gap_style = 1;
        write_regs(9'd511, 32'h10000, 32'h18000, $urandom);
        for (int i = 0; i < 30; i++)
            reach_query(90);
        settle();
        write_regs(9'd256, 32'h8000, 32'h10000, 32'h0);
        for (int i = 0; i < 15; i++)
            reach_query(90);
        settle();

        $display("covered %0d loads and %0d queries, %0d results checked",
                 sb.loads, sb.queries, sb.results);
        $display("settings spanned size, spacing and centre extremes, with one long output stall");
        if (sb.mismatches == 0 && sb.awaiting.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
